>>> rtl/wrlh_pkg.sv
package wrlh_pkg;

    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 4;
    localparam int TIMER_W = 10;
    localparam int CFG_W   = 10;

    // op codes of an input word
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // kinds of a result word
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_RDATA   = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;
    localparam logic [1:0] KIND_REFUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ACK_WAIT   = 2'd0;
    localparam logic [1:0] CFG_RETRY_WAIT = 2'd1;
    localparam logic [1:0] CFG_ACK_VALUE  = 2'd2;

    localparam logic [TIMER_W-1:0] ACK_WAIT_RST   = 10'd100;
    localparam logic [TIMER_W-1:0] RETRY_WAIT_RST = 10'd500;
    localparam logic [BYTE_W-1:0]  ACK_VALUE_RST  = 8'd255;

    localparam logic [ADDR_W:0] READ_FLAG = 5'h10;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WAIT_ACK,
        MODE_WAIT_RESEND,
        MODE_WAIT_READ
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_RS_READ,
        ST_RS_ADDR,
        ST_RS_DATA
    } t_seq;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_result;

endpackage

>>> rtl/wrlh_ram.sv
module wrlh_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/windowed_register_link_host_top.sv
// channel  | valid   | ready   | payload
// ---------+---------+---------+------------------------------------------
// input    | i_valid | o_ready | i_op, i_addr, i_wdata, i_rx_byte
// output   | o_valid | i_ready | o_kind, o_value, o_last
// config   | i_cfg_we| -       | i_cfg_index, i_cfg_data
//
// one input word at a time; a write request sends two bytes through the output
// register, the address byte and then the data byte
// a window resend walks every held pair: each held pair is one read of
// the single-port-read window ram, then its address and data bytes
// reset (i_rst_n low, synchronous) clears mode, counters, timer and config
// a stalled output holds the sequencer; o_ready is low until it drains
module windowed_register_link_host_top #(
    parameter int WINDOW_PAIRS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_value,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    localparam int PW = (WINDOW_PAIRS > 1) ? $clog2(WINDOW_PAIRS) : 1;
    localparam logic [PW-1:0] LAST_PAIR = PW'(WINDOW_PAIRS - 1);
    localparam int EW = wrlh_pkg::ADDR_W + wrlh_pkg::BYTE_W;

    // configuration
    logic [wrlh_pkg::TIMER_W-1:0] r_ack_wait;
    logic [wrlh_pkg::TIMER_W-1:0] r_retry_wait;
    logic [wrlh_pkg::BYTE_W-1:0]  r_ack_value;

    // link state
    wrlh_pkg::t_mode              r_mode,  n_mode;
    logic [PW-1:0]                r_pairs, n_pairs;
    logic [wrlh_pkg::TIMER_W-1:0] r_timer, n_timer;
    logic [wrlh_pkg::ADDR_W:0]    r_pend,  n_pend;

    // sequencer
    wrlh_pkg::t_seq               r_seq,   n_seq;
    logic [PW-1:0]                r_pidx,  n_pidx;
    logic [wrlh_pkg::BYTE_W-1:0]  r_hold,  n_hold;

    // output register
    logic                         r_out_valid;
    wrlh_pkg::t_result            r_res;
    wrlh_pkg::t_result            res;
    logic                         load_out;

    logic                         out_free;
    logic                         accept;
    logic                         emit_second;
    logic                         start_resend;
    logic [wrlh_pkg::TIMER_W-1:0] timer_dec;
    logic                         ram_we;
    logic                         ram_re;
    logic [EW-1:0]                ram_rdata;

    assign out_free  = !r_out_valid || i_ready;
    assign o_ready   = (r_seq == wrlh_pkg::ST_IDLE) && out_free;
    assign accept    = i_valid && o_ready;
    assign timer_dec = (r_timer == '0) ? '0 : r_timer - 1'b1;

    // window pairs are written only from idle and read only during a resend,
    // so the two never touch the same entry in overlapping cycles
    wrlh_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW_PAIRS)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pairs),
        .i_wdata ({i_addr, i_wdata}),
        .i_re    (ram_re),
        .i_raddr (r_pidx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            wrlh_pkg::ST_IDLE: begin
                if (emit_second) begin
                    n_seq = wrlh_pkg::ST_EMIT;
                end else if (start_resend) begin
                    n_seq = wrlh_pkg::ST_RS_READ;
                end
            end
            wrlh_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_seq = wrlh_pkg::ST_IDLE;
                end
            end
            wrlh_pkg::ST_RS_READ: begin
                n_seq = wrlh_pkg::ST_RS_ADDR;
            end
            wrlh_pkg::ST_RS_ADDR: begin
                if (out_free) begin
                    n_seq = wrlh_pkg::ST_RS_DATA;
                end
            end
            wrlh_pkg::ST_RS_DATA: begin
                if (out_free) begin
                    n_seq = (r_pidx == LAST_PAIR) ? wrlh_pkg::ST_IDLE : wrlh_pkg::ST_RS_READ;
                end
            end
            default: begin
                n_seq = wrlh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_mode       = r_mode;
        n_pairs      = r_pairs;
        n_timer      = r_timer;
        n_pend       = r_pend;
        n_hold       = r_hold;
        n_pidx       = r_pidx;
        load_out     = 1'b0;
        res          = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        emit_second  = 1'b0;
        start_resend = 1'b0;
        case (r_seq)
            wrlh_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        wrlh_pkg::OP_WRITE, wrlh_pkg::OP_READ: begin
                            load_out = 1'b1;
                            if (r_mode != wrlh_pkg::MODE_IDLE) begin
                                res = '{kind: wrlh_pkg::KIND_REFUSED, value: '0, last: 1'b1};
                            end else if (i_op == wrlh_pkg::OP_WRITE) begin
                                res = '{kind: wrlh_pkg::KIND_TX, value: {4'b0, i_addr},
                                        last: 1'b0};
                                n_hold      = i_wdata;
                                ram_we      = 1'b1;
                                emit_second = 1'b1;
                                if (r_pairs == LAST_PAIR) begin
                                    n_pairs = '0;
                                    n_mode  = wrlh_pkg::MODE_WAIT_ACK;
                                    n_timer = r_ack_wait;
                                end else begin
                                    n_pairs = r_pairs + 1'b1;
                                end
                            end else begin
                                n_pend  = wrlh_pkg::READ_FLAG | {1'b0, i_addr};
                                res     = '{kind: wrlh_pkg::KIND_TX,
                                            value: {3'b0, wrlh_pkg::READ_FLAG | {1'b0, i_addr}},
                                            last: 1'b1};
                                n_mode  = wrlh_pkg::MODE_WAIT_READ;
                                n_timer = r_retry_wait;
                            end
                        end
                        wrlh_pkg::OP_RX: begin
                            if (r_mode == wrlh_pkg::MODE_WAIT_ACK ||
                                r_mode == wrlh_pkg::MODE_WAIT_RESEND) begin
                                if (i_rx_byte == r_ack_value) begin
                                    load_out = 1'b1;
                                    res      = '{kind: wrlh_pkg::KIND_ACK, value: '0,
                                                 last: 1'b1};
                                    n_mode   = wrlh_pkg::MODE_IDLE;
                                    n_timer  = '0;
                                end else begin
                                    start_resend = 1'b1;
                                end
                            end else if (r_mode == wrlh_pkg::MODE_WAIT_READ) begin
                                load_out = 1'b1;
                                res      = '{kind: wrlh_pkg::KIND_RDATA, value: i_rx_byte,
                                             last: 1'b1};
                                n_mode   = wrlh_pkg::MODE_IDLE;
                                n_timer  = '0;
                            end
                        end
                        wrlh_pkg::OP_TICK: begin
                            if (r_mode != wrlh_pkg::MODE_IDLE) begin
                                n_timer = timer_dec;
                                if (timer_dec == '0) begin
                                    if (r_mode == wrlh_pkg::MODE_WAIT_READ) begin
                                        load_out = 1'b1;
                                        res      = '{kind: wrlh_pkg::KIND_TX,
                                                     value: {3'b0, r_pend}, last: 1'b1};
                                        n_timer  = r_retry_wait;
                                    end else begin
                                        start_resend = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                    if (start_resend) begin
                        n_mode  = wrlh_pkg::MODE_WAIT_RESEND;
                        n_timer = r_retry_wait;
                        n_pidx  = '0;
                    end
                end
            end
            wrlh_pkg::ST_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    res      = '{kind: wrlh_pkg::KIND_TX, value: r_hold, last: 1'b1};
                end
            end
            wrlh_pkg::ST_RS_READ: begin
                ram_re = 1'b1;
            end
            wrlh_pkg::ST_RS_ADDR: begin
                if (out_free) begin
                    load_out = 1'b1;
                    res      = '{kind: wrlh_pkg::KIND_TX,
                                 value: {4'b0, ram_rdata[EW-1:wrlh_pkg::BYTE_W]}, last: 1'b0};
                end
            end
            wrlh_pkg::ST_RS_DATA: begin
                if (out_free) begin
                    load_out = 1'b1;
                    res      = '{kind: wrlh_pkg::KIND_TX,
                                 value: ram_rdata[wrlh_pkg::BYTE_W-1:0],
                                 last: (r_pidx == LAST_PAIR)};
                    if (r_pidx != LAST_PAIR) begin
                        n_pidx = r_pidx + 1'b1;
                    end
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_wait   <= wrlh_pkg::ACK_WAIT_RST;
            r_retry_wait <= wrlh_pkg::RETRY_WAIT_RST;
            r_ack_value  <= wrlh_pkg::ACK_VALUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wrlh_pkg::CFG_ACK_WAIT:   r_ack_wait   <= i_cfg_data;
                wrlh_pkg::CFG_RETRY_WAIT: r_retry_wait <= i_cfg_data;
                wrlh_pkg::CFG_ACK_VALUE:  r_ack_value  <= i_cfg_data[wrlh_pkg::BYTE_W-1:0];
                default: begin
                    r_ack_value <= r_ack_value;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= wrlh_pkg::MODE_IDLE;
            r_pairs     <= '0;
            r_timer     <= '0;
            r_pend      <= '0;
            r_seq       <= wrlh_pkg::ST_IDLE;
            r_pidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pairs <= n_pairs;
            r_timer <= n_timer;
            r_pend  <= n_pend;
            r_seq   <= n_seq;
            r_pidx  <= n_pidx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (load_out) begin
            r_res <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_res.kind;
    assign o_value = r_res.value;
    assign o_last  = r_res.last;

endmodule

>>> sim/tb_windowed_register_link_host_top.sv
module tb_windowed_register_link_host_top;

    localparam int PAIRS        = 6;
    localparam int DRAIN_CYCLES = 3 * PAIRS + 22;
    localparam int HOLD_CYCLES  = 200;
    localparam logic [1:0] CFG_NO_REG = 2'd3;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_ONE,
        CHK_NONE
    } t_chk;

    typedef struct packed {
        t_chk       chk;
        logic [1:0] op;
        logic [3:0] addr;
        logic [7:0] wdata;
        logic [7:0] rx;
        logic [1:0] kind;
        logic [7:0] value;
    } t_step;

    logic       clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_op = wrlh_pkg::OP_TICK;
    logic [3:0] i_addr = 4'h0;
    logic [7:0] i_wdata = 8'h00;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = wrlh_pkg::CFG_ACK_WAIT;
    logic [9:0] i_cfg_data = 10'd0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_value;
    logic       o_last;

    // link state as the host should see it
    wrlh_pkg::t_mode host_mode = wrlh_pkg::MODE_IDLE;
    int          pair_count = 0;
    logic [7:0]  window_copy [2*PAIRS];
    logic [9:0]  ticks_left = 10'd0;
    logic [4:0]  read_addr_byte = 5'd0;
    logic [9:0]  cfg_ack_wait = wrlh_pkg::ACK_WAIT_RST;
    logic [9:0]  cfg_retry_wait = wrlh_pkg::RETRY_WAIT_RST;
    logic [7:0]  cfg_ack_byte = wrlh_pkg::ACK_VALUE_RST;

    wrlh_pkg::t_result due_words [$];
    int      err_count = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      hold_tag = 0;
    int      hold_seen = 0;
    int      hold_left = 0;

    // ack_wait 2, retry 1, ack byte a5 while these run
    t_step directed_steps [27] = '{
        '{CHK_NONE,  wrlh_pkg::OP_TICK,  4'h0, 8'h00, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_NONE,  wrlh_pkg::OP_RX,    4'h0, 8'h00, 8'h5a, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_ONE,   wrlh_pkg::OP_READ,  4'h0, 8'h00, 8'h00, wrlh_pkg::KIND_TX,      8'h10},
        '{CHK_ONE,   wrlh_pkg::OP_WRITE, 4'h3, 8'h77, 8'h00, wrlh_pkg::KIND_REFUSED, 8'h00},
        '{CHK_ONE,   wrlh_pkg::OP_TICK,  4'h0, 8'h00, 8'h00, wrlh_pkg::KIND_TX,      8'h10},
        '{CHK_ONE,   wrlh_pkg::OP_RX,    4'h0, 8'h00, 8'hff, wrlh_pkg::KIND_RDATA,   8'hff},
        '{CHK_ONE,   wrlh_pkg::OP_READ,  4'hf, 8'hff, 8'h00, wrlh_pkg::KIND_TX,      8'h1f},
        '{CHK_ONE,   wrlh_pkg::OP_RX,    4'h0, 8'h00, 8'h00, wrlh_pkg::KIND_RDATA,   8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'h0, 8'h00, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'hf, 8'hff, 8'hff, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'h5, 8'h55, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'ha, 8'haa, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'h3, 8'h01, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'hc, 8'h80, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_ONE,   wrlh_pkg::OP_READ,  4'h7, 8'h00, 8'h00, wrlh_pkg::KIND_REFUSED, 8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_RX,    4'h0, 8'h00, 8'h5a, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_TICK,  4'h0, 8'h00, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_ONE,   wrlh_pkg::OP_RX,    4'h0, 8'h00, 8'ha5, wrlh_pkg::KIND_ACK,     8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'h1, 8'h12, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'h2, 8'h34, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'h4, 8'h56, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'h8, 8'h78, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'h9, 8'h9a, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_WRITE, 4'he, 8'hbc, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_NONE,  wrlh_pkg::OP_TICK,  4'h0, 8'h00, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_MODEL, wrlh_pkg::OP_TICK,  4'h0, 8'h00, 8'h00, wrlh_pkg::KIND_TX,      8'h00},
        '{CHK_ONE,   wrlh_pkg::OP_RX,    4'h0, 8'h00, 8'ha5, wrlh_pkg::KIND_ACK,     8'h00}
    };

    windowed_register_link_host_top #(
        .WINDOW_PAIRS(PAIRS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_addr     (i_addr),
        .i_wdata    (i_wdata),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_value    (o_value),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic replay_window(ref wrlh_pkg::t_result words [$]);
        for (int i = 0; i < 2 * PAIRS; i++)
            words.push_back({wrlh_pkg::KIND_TX, window_copy[i], 1'b0});
        host_mode  = wrlh_pkg::MODE_WAIT_RESEND;
        ticks_left = cfg_retry_wait;
    endtask

    task automatic compute_link_output(input logic [1:0] op, input logic [3:0] addr,
                                       input logic [7:0] wdata, input logic [7:0] rx,
                                       ref wrlh_pkg::t_result words [$]);
        wrlh_pkg::t_result tail;
        if (op == wrlh_pkg::OP_WRITE || op == wrlh_pkg::OP_READ) begin
            if (host_mode != wrlh_pkg::MODE_IDLE) begin
                words.push_back({wrlh_pkg::KIND_REFUSED, 8'h00, 1'b0});
            end else if (op == wrlh_pkg::OP_WRITE) begin
                words.push_back({wrlh_pkg::KIND_TX, {4'h0, addr}, 1'b0});
                words.push_back({wrlh_pkg::KIND_TX, wdata, 1'b0});
                window_copy[2*pair_count]   = {4'h0, addr};
                window_copy[2*pair_count+1] = wdata;
                if (pair_count + 1 >= PAIRS) begin
                    pair_count = 0;
                    host_mode  = wrlh_pkg::MODE_WAIT_ACK;
                    ticks_left = cfg_ack_wait;
                end else begin
                    pair_count++;
                end
            end else begin
                read_addr_byte = {1'b0, addr} | wrlh_pkg::READ_FLAG;
                words.push_back({wrlh_pkg::KIND_TX, {3'b000, read_addr_byte}, 1'b0});
                host_mode  = wrlh_pkg::MODE_WAIT_READ;
                ticks_left = cfg_retry_wait;
            end
        end else if (op == wrlh_pkg::OP_RX) begin
            if (host_mode == wrlh_pkg::MODE_WAIT_ACK ||
                host_mode == wrlh_pkg::MODE_WAIT_RESEND) begin
                if (rx == cfg_ack_byte) begin
                    words.push_back({wrlh_pkg::KIND_ACK, 8'h00, 1'b0});
                    host_mode  = wrlh_pkg::MODE_IDLE;
                    ticks_left = 10'd0;
                end else begin
                    replay_window(words);
                end
            end else if (host_mode == wrlh_pkg::MODE_WAIT_READ) begin
                words.push_back({wrlh_pkg::KIND_RDATA, rx, 1'b0});
                host_mode  = wrlh_pkg::MODE_IDLE;
                ticks_left = 10'd0;
            end
        end else if (host_mode != wrlh_pkg::MODE_IDLE) begin
            // a zero wait value fires on the first tick
            if (ticks_left != 10'd0)
                ticks_left--;
            if (ticks_left == 10'd0) begin
                if (host_mode == wrlh_pkg::MODE_WAIT_READ) begin
                    words.push_back({wrlh_pkg::KIND_TX, {3'b000, read_addr_byte}, 1'b0});
                    ticks_left = cfg_retry_wait;
                end else begin
                    replay_window(words);
                end
            end
        end
        if (words.size() > 0) begin
            tail = words[words.size()-1];
            tail.last = 1'b1;
            words[words.size()-1] = tail;
        end
    endtask

    task automatic send_word(input logic [1:0] op, input logic [3:0] addr,
                             input logic [7:0] wdata, input logic [7:0] rx,
                             input t_chk chk, input logic [1:0] kind,
                             input logic [7:0] value);
        wrlh_pkg::t_result words [$];
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_addr    <= addr;
        i_wdata   <= wdata;
        i_rx_byte <= rx;
        @(posedge clk);
        while (!o_ready)
            @(posedge clk);
        compute_link_output(op, addr, wdata, rx, words);
        if (chk == CHK_MODEL) begin
            foreach (words[i])
                due_words.push_back(words[i]);
        end else if (chk == CHK_ONE) begin
            due_words.push_back({kind, value, 1'b1});
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        @(negedge clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            wrlh_pkg::CFG_ACK_WAIT:   cfg_ack_wait   = data;
            wrlh_pkg::CFG_RETRY_WAIT: cfg_retry_wait = data;
            wrlh_pkg::CFG_ACK_VALUE:  cfg_ack_byte   = data[7:0];
            default: ;
        endcase
    endtask

    // drop valid and wait until every expected word is back
    task automatic hold_input();
        @(negedge clk);
        i_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        hold_input();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly what the current wait expects, some refused requests and noise
    task automatic pick_word(output logic [1:0] op, output logic [3:0] addr,
                             output logic [7:0] wdata, output logic [7:0] rx);
        int unsigned r;
        r     = $urandom_range(99);
        addr  = 4'($urandom);
        wdata = 8'($urandom);
        rx    = 8'($urandom);
        case (host_mode)
            wrlh_pkg::MODE_IDLE: begin
                if (r < 45)      op = wrlh_pkg::OP_WRITE;
                else if (r < 75) op = wrlh_pkg::OP_READ;
                else if (r < 88) op = wrlh_pkg::OP_RX;
                else             op = wrlh_pkg::OP_TICK;
            end
            wrlh_pkg::MODE_WAIT_READ: begin
                if (r < 50)      op = wrlh_pkg::OP_RX;
                else if (r < 80) op = wrlh_pkg::OP_TICK;
                else             op = ($urandom_range(1) == 0) ? wrlh_pkg::OP_WRITE
                                                                : wrlh_pkg::OP_READ;
            end
            default: begin
                if (r < 40) begin
                    op = wrlh_pkg::OP_TICK;
                end else if (r < 70) begin
                    op = wrlh_pkg::OP_RX;
                    rx = cfg_ack_byte;
                end else if (r < 88) begin
                    op = wrlh_pkg::OP_RX;
                end else begin
                    op = ($urandom_range(1) == 0) ? wrlh_pkg::OP_WRITE : wrlh_pkg::OP_READ;
                end
            end
        endcase
    endtask

    task automatic run_phase(input int n_words, input int pause_at);
        int         done;
        logic [1:0] op;
        logic [3:0] addr;
        logic [7:0] wdata;
        logic [7:0] rx;
        done = 0;
        while (done < n_words) begin
            if (done == pause_at)
                hold_input();
            pick_word(op, addr, wdata, rx);
            // stray bytes and ticks while idle do not count
            if (!(host_mode == wrlh_pkg::MODE_IDLE &&
                  (op == wrlh_pkg::OP_RX || op == wrlh_pkg::OP_TICK)))
                done++;
            send_word(op, addr, wdata, rx, CHK_MODEL, wrlh_pkg::KIND_TX, 8'h00);
        end
        settle();
    endtask

    // result side: random stalls, plus a long hold-off when requested
    always @(negedge clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        wrlh_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d value %02h last %b",
                                          o_kind, o_value, o_last));
            end else begin
                want = due_words.pop_front();
                if (o_kind !== want.kind || o_value !== want.value || o_last !== want.last)
                    report_mismatch($sformatf(
                        "word kind %0d/%0d value %02h/%02h last %b/%b (got/exp)",
                        o_kind, want.kind, o_value, want.value, o_last, want.last));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        foreach (window_copy[i])
            window_copy[i] = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        i_rst_n <= 1'b1;

        write_reg(wrlh_pkg::CFG_ACK_WAIT, 10'd2);
        write_reg(wrlh_pkg::CFG_RETRY_WAIT, 10'd1);
        write_reg(wrlh_pkg::CFG_ACK_VALUE, 10'h0a5);
        foreach (directed_steps[k])
            send_word(directed_steps[k].op, directed_steps[k].addr, directed_steps[k].wdata,
                      directed_steps[k].rx, directed_steps[k].chk, directed_steps[k].kind,
                      directed_steps[k].value);
        settle();

        write_reg(wrlh_pkg::CFG_ACK_WAIT, 10'd3);
        write_reg(wrlh_pkg::CFG_RETRY_WAIT, 10'd2);
        write_reg(wrlh_pkg::CFG_ACK_VALUE, 10'h000);
        run_phase(40, -1);

        // zero waits behave like one tick
        @(posedge clk);
        idle_pct = 85;
        write_reg(wrlh_pkg::CFG_ACK_WAIT, 10'd0);
        write_reg(wrlh_pkg::CFG_RETRY_WAIT, 10'd0);
        write_reg(wrlh_pkg::CFG_ACK_VALUE, 10'h0ff);
        run_phase(30, -1);

        @(posedge clk);
        idle_pct  = 0;
        stall_pct = 85;
        write_reg(wrlh_pkg::CFG_ACK_WAIT, 10'd1023);
        write_reg(wrlh_pkg::CFG_RETRY_WAIT, 10'd1023);
        write_reg(wrlh_pkg::CFG_ACK_VALUE, 10'h33c);
        write_reg(CFG_NO_REG, 10'h3ff);
        run_phase(30, -1);

        @(posedge clk);
        idle_pct  = 20;
        stall_pct = 20;
        write_reg(wrlh_pkg::CFG_ACK_WAIT, 10'd1);
        write_reg(wrlh_pkg::CFG_RETRY_WAIT, 10'd1);
        write_reg(wrlh_pkg::CFG_ACK_VALUE, 10'($urandom_range(255)));
        run_phase(30, 20);

        // long result stall with the sender pushing flat out
        @(posedge clk);
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(wrlh_pkg::CFG_ACK_WAIT, 10'd2);
        write_reg(wrlh_pkg::CFG_RETRY_WAIT, 10'($urandom_range(8, 1)));
        write_reg(wrlh_pkg::CFG_ACK_VALUE, 10'h081);
        @(posedge clk);
        hold_tag = hold_tag + 1;
        run_phase(30, -1);

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/wrlh_pkg.sv
rtl/wrlh_ram.sv
rtl/windowed_register_link_host_top.sv
sim/tb_windowed_register_link_host_top.sv
